FILE: hw/rtl/msp_fr_pkg.sv
// Shared types and constants of the MSP frame receiver.
package msp_fr_pkg;

   // Frame delimiter characters.
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_LT     = 8'h3C;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_IDLE    = 2'd2;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_GOT_DOLLAR = 3'd1,
      PH_GOT_M      = 3'd2,
      PH_SIZE       = 3'd3,
      PH_CMD        = 3'd4,
      PH_DATA       = 3'd5
   } phase_type;

   // Emitter states.
   typedef enum logic [1:0] {
      EM_IDLE = 2'd0,
      EM_READ = 2'd1,
      EM_EMIT = 2'd2
   } em_state_type;

   // Work handed from the parser to the emitter. A payload kind means a stored frame.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cmd;
      logic [7:0] data;
      logic [6:0] len;
   } job_type;

   // One result word.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cmd;
      logic [7:0] data;
      logic [6:0] len;
      logic       last;
   } rsp_type;

endpackage

FILE: hw/rtl/msp_fr_fifo.sv
// Small first-in first-out queue of packed words.
module msp_fr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/msp_fr_parser.sv
// Front part: frame parser, checksum and payload store.
module msp_fr_parser
   import msp_fr_pkg::*;
#(
   parameter int PAYLOAD_CAPACITY = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_rx_byte,
   output logic              req_full,
   output logic              job_push,
   output job_type           job_word,
   input  logic              job_full,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              store_release
);

   phase_type   phase_ff, phase_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  fill_ff, fill_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  csum_ff, csum_in;
   logic        busy_ff;
   logic        busy_set;
   logic        mem_we;
   logic        accept;
   logic        filling;
   logic [7:0]  payload_store_ff [PAYLOAD_CAPACITY];
   logic [7:0]  rd_data_ff;

   // A payload word may not be stored while the previous frame still drains.
   assign filling  = (phase_ff == PH_DATA) && (fill_ff < len_ff);
   assign req_full = job_full || (busy_ff && filling);
   assign accept   = req_push && !req_full;
   assign rd_data  = rd_data_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_GOT_DOLLAR: phase_in = (req_rx_byte == CHAR_M) ? PH_GOT_M : PH_IDLE;
            PH_GOT_M:      phase_in = (req_rx_byte == CHAR_LT) ? PH_SIZE : PH_IDLE;
            PH_SIZE:       phase_in = (req_rx_byte > 8'(PAYLOAD_CAPACITY)) ? PH_IDLE : PH_CMD;
            PH_CMD:        phase_in = PH_DATA;
            PH_DATA:       phase_in = filling ? PH_DATA : PH_IDLE;
            default:       phase_in = (req_rx_byte == CHAR_DOLLAR) ? PH_GOT_DOLLAR : PH_IDLE;
         endcase
      end
   end

   // Datapath updates and job issue for the accepted word.
   always_comb begin
      len_in   = len_ff;
      fill_in  = fill_ff;
      cmd_in   = cmd_ff;
      csum_in  = csum_ff;
      mem_we   = 1'b0;
      busy_set = 1'b0;
      job_push = 1'b0;
      job_word = '{kind: KIND_IDLE, cmd: 8'd0, data: req_rx_byte, len: 7'd0};
      if (accept) begin
         case (phase_ff)
            PH_GOT_DOLLAR, PH_GOT_M: begin
            end
            PH_SIZE: begin
               if (req_rx_byte <= 8'(PAYLOAD_CAPACITY)) begin
                  len_in  = req_rx_byte[6:0];
                  fill_in = 7'd0;
                  csum_in = req_rx_byte;
               end
            end
            PH_CMD: begin
               cmd_in  = req_rx_byte;
               csum_in = csum_ff ^ req_rx_byte;
            end
            PH_DATA: begin
               if (filling) begin
                  mem_we  = 1'b1;
                  csum_in = csum_ff ^ req_rx_byte;
                  fill_in = fill_ff + 7'd1;
               end else if (req_rx_byte == csum_ff) begin
                  job_push = 1'b1;
                  if (len_ff == 7'd0) begin
                     job_word = '{kind: KIND_EMPTY, cmd: cmd_ff, data: 8'd0, len: 7'd0};
                  end else begin
                     job_word = '{kind: KIND_PAYLOAD, cmd: cmd_ff, data: 8'd0, len: len_ff};
                     busy_set = 1'b1;
                  end
               end
            end
            default: begin
               job_push = (req_rx_byte != CHAR_DOLLAR);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         fill_ff  <= '0;
         cmd_ff   <= '0;
         csum_ff  <= '0;
         busy_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         cmd_ff   <= cmd_in;
         csum_ff  <= csum_in;
         if (busy_set) begin
            busy_ff <= 1'b1;
         end else if (store_release) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Payload store: one write port for the parser, one registered read port for the emitter.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_store_ff[fill_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= payload_store_ff[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/msp_fr_emitter.sv
// Back part: turns queued jobs into result words, draining stored frames.
module msp_fr_emitter
   import msp_fr_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  job_type           job_word,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              store_release,
   output logic              out_push,
   output rsp_type           out_word,
   input  logic              out_full
);

   em_state_type state_ff, state_in;
   logic [7:0]   cmd_ff;
   logic [6:0]   len_ff;
   logic [6:0]   idx_ff;
   logic         is_frame;
   logic         is_last;

   assign is_frame = (job_word.kind == KIND_PAYLOAD);
   assign is_last  = (idx_ff == (len_ff - 7'd1));
   assign rd_addr  = idx_ff[ADDR_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EM_IDLE: begin
            if (!job_empty && is_frame) begin
               state_in = EM_READ;
            end
         end
         EM_READ: state_in = EM_EMIT;
         EM_EMIT: begin
            if (!out_full) begin
               state_in = is_last ? EM_IDLE : EM_READ;
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      job_pop       = 1'b0;
      rd_en         = 1'b0;
      store_release = 1'b0;
      out_push      = 1'b0;
      out_word      = '{kind: job_word.kind, cmd: job_word.cmd, data: job_word.data,
                        len: job_word.len, last: 1'b1};
      case (state_ff)
         EM_IDLE: begin
            job_pop  = !job_empty && (is_frame || !out_full);
            out_push = !job_empty && !is_frame && !out_full;
         end
         EM_READ: begin
            rd_en         = 1'b1;
            store_release = is_last;
         end
         EM_EMIT: begin
            out_push = !out_full;
            out_word = '{kind: KIND_PAYLOAD, cmd: cmd_ff, data: rd_data, len: len_ff,
                         last: is_last};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == EM_IDLE && job_pop && is_frame) begin
            idx_ff <= 7'd0;
         end else if (state_ff == EM_EMIT && out_push && !is_last) begin
            idx_ff <= idx_ff + 7'd1;
         end
      end
   end

   // Frame header held for the whole drain.
   always_ff @(posedge clock) begin
      if (state_ff == EM_IDLE && job_pop && is_frame) begin
         cmd_ff <= job_word.cmd;
         len_ff <= job_word.len;
      end
   end

endmodule

FILE: hw/rtl/msp_frame_receiver_unit.sv
// Top level of the MSP request frame receiver.
//
//   Channel   Ports                                   Word
//   req       req_push, req_full, req_rx_byte         one received serial byte
//   rsp       rsp_pop, rsp_empty, rsp_kind, ...       one result word
//
// A byte is taken when req_full is low; bytes that start no result pass
// straight through the parser. A single result word (idle byte or empty
// frame) is registered in the job queue and leaves the emitter once the
// emitter is idle and the result queue has room. A good frame of N payload
// bytes drains with one store read and one queue write per byte. Payload
// bytes of the next frame stall while the store still drains. Reset is
// synchronous and empties both queues; the store needs no clearing.
module msp_frame_receiver_unit
   import msp_fr_pkg::*;
#(
   parameter int PAYLOAD_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_frame_length,
   output logic       rsp_last
);

   localparam int ADDR_W = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
   localparam int JOB_W  = $bits(job_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic              job_push, job_full, job_pop, job_empty;
   job_type           job_in_word;
   logic [JOB_W-1:0]  job_out_bits;
   logic              rd_en, store_release;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              out_push, out_full;
   rsp_type           out_word;
   logic [RSP_W-1:0]  rsp_bits;
   rsp_type           rsp_word;

   // Front: parsing and payload store.
   msp_fr_parser #(
      .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY),
      .ADDR_W(ADDR_W)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_rx_byte(req_rx_byte),
      .req_full(req_full),
      .job_push(job_push),
      .job_word(job_in_word),
      .job_full(job_full),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .store_release(store_release)
   );

   // Job queue between the two parts.
   msp_fr_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(2)
   ) u_job_fifo (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(job_in_word),
      .full(job_full),
      .pop(job_pop),
      .pop_data(job_out_bits),
      .empty(job_empty)
   );

   // Back: result generation.
   msp_fr_emitter #(
      .ADDR_W(ADDR_W)
   ) u_emitter (
      .clock(clock),
      .reset(reset),
      .job_word(job_type'(job_out_bits)),
      .job_empty(job_empty),
      .job_pop(job_pop),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .store_release(store_release),
      .out_push(out_push),
      .out_word(out_word),
      .out_full(out_full)
   );

   // Result queue facing the consumer.
   msp_fr_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_data(out_word),
      .full(out_full),
      .pop(rsp_pop),
      .pop_data(rsp_bits),
      .empty(rsp_empty)
   );

   // Unpack the oldest result onto the ports.
   assign rsp_word         = rsp_type'(rsp_bits);
   assign rsp_kind         = rsp_word.kind;
   assign rsp_command_code = rsp_word.cmd;
   assign rsp_data_byte    = rsp_word.data;
   assign rsp_frame_length = rsp_word.len;
   assign rsp_last         = rsp_word.last;

endmodule

FILE: tb/sv/msp_frame_receiver_unit_tb_pkg.sv
// Frame decoder model and result checker for the MSP frame receiver testbench.
package msp_frame_receiver_tb_pkg;
   import msp_fr_pkg::*;

   localparam int FRAME_CAPACITY = 64;

   class frame_decode_model;
      // Parser state of the modeled receiver.
      phase_type        phase;
      logic [6:0]       want_len;
      logic [6:0]       filled;
      logic [7:0]       frame_cmd;
      logic [7:0]       xor_sum;
      logic [7:0]       payload_mem [FRAME_CAPACITY];

      // Result words that the receiver still owes, oldest first.
      rsp_type          due_words [$];
      int               bad_words;
      int               checked_words;

      function new();
         phase     = PH_IDLE;
         want_len  = '0;
         filled    = '0;
         frame_cmd = '0;
         xor_sum   = '0;
         bad_words = 0;
         checked_words = 0;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      task report_mismatch(string msg);
         bad_words++;
         $display("MISMATCH: %s", msg);
      endtask

      function void push_word(logic [1:0] kind, logic [7:0] cmd, logic [7:0] data,
                              logic [6:0] len, logic last);
         rsp_type w;
         w.kind = kind;
         w.cmd  = cmd;
         w.data = data;
         w.len  = len;
         w.last = last;
         due_words.push_back(w);
      endfunction

      // Advance the parser by one accepted byte and queue the words it causes.
      function void take_byte(logic [7:0] b);
         case (phase)
            PH_GOT_DOLLAR: begin
               phase = (b == CHAR_M) ? PH_GOT_M : PH_IDLE;
            end
            PH_GOT_M: begin
               phase = (b == CHAR_LT) ? PH_SIZE : PH_IDLE;
            end
            PH_SIZE: begin
               if (int'(b) > FRAME_CAPACITY) begin
                  phase = PH_IDLE;
               end else begin
                  want_len = b[6:0];
                  filled   = '0;
                  xor_sum  = b;
                  phase    = PH_CMD;
               end
            end
            PH_CMD: begin
               frame_cmd = b;
               xor_sum   = xor_sum ^ b;
               phase     = PH_DATA;
            end
            PH_DATA: begin
               if (filled < want_len) begin
                  payload_mem[filled] = b;
                  xor_sum = xor_sum ^ b;
                  filled  = filled + 7'd1;
               end else begin
                  // A good checksum releases the whole frame at once.
                  if (b == xor_sum) begin
                     if (want_len == 0) begin
                        push_word(KIND_EMPTY, frame_cmd, 8'h00, 7'd0, 1'b1);
                     end else begin
                        for (int i = 0; i < int'(want_len); i++)
                           push_word(KIND_PAYLOAD, frame_cmd, payload_mem[i], want_len,
                                     (i + 1 == int'(want_len)));
                     end
                  end
                  phase = PH_IDLE;
               end
            end
            default: begin
               // Any byte but the frame start leaves idle as an unconsumed byte.
               if (b == CHAR_DOLLAR) begin
                  phase = PH_GOT_DOLLAR;
               end else begin
                  phase = PH_IDLE;
                  push_word(KIND_IDLE, 8'h00, b, 7'd0, 1'b1);
               end
            end
         endcase
      endfunction

      // Compare one popped word with the oldest word owed.
      task check_word(rsp_type got);
         rsp_type want;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf(
               "unexpected word kind=%0d cmd=%02h data=%02h len=%0d last=%0b",
               got.kind, got.cmd, got.data, got.len, got.last));
            return;
         end
         want = due_words.pop_front();
         if (got.kind !== want.kind || got.cmd !== want.cmd || got.data !== want.data ||
             got.len !== want.len || got.last !== want.last)
            report_mismatch($sformatf(
               "word %0d got kind=%0d cmd=%02h data=%02h len=%0d last=%0b, %s",
               checked_words, got.kind, got.cmd, got.data, got.len, got.last,
               $sformatf("want kind=%0d cmd=%02h data=%02h len=%0d last=%0b",
                         want.kind, want.cmd, want.data, want.len, want.last)));
         checked_words++;
      endtask
   endclass

endpackage

FILE: tb/sv/msp_frame_receiver_unit_tb.sv
// Testbench top that feeds serial bytes to the MSP frame receiver and checks its words.
module msp_frame_receiver_unit_tb;
   import msp_fr_pkg::*;
   import msp_frame_receiver_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 140;
   localparam int RANDOM_BYTES  = 260;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic [7:0] req_rx_byte;
   logic       req_full;
   logic       rsp_pop;
   logic       rsp_empty;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_command_code;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_frame_length;
   logic       rsp_last;

   frame_decode_model decoder;
   int                cycle_count = 0;
   int                fed_bytes   = 0;
   bit                fast_feed   = 1'b0;

   msp_frame_receiver_unit #(
      .PAYLOAD_CAPACITY(FRAME_CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_kind         (rsp_kind),
      .rsp_command_code (rsp_command_code),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the receiver hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Push one byte after a random gap; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = fast_feed ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0)
         fast_feed = !fast_feed;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      decoder.take_byte(b);
      fed_bytes++;
      @(negedge clock);
   endtask

   // Send a full request frame with random payload and a good or corrupted checksum.
   task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit good);
      logic [7:0] sum;
      logic [7:0] b;
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_byte(CHAR_LT);
      send_byte(len);
      send_byte(cmd);
      sum = len ^ cmd;
      for (int i = 0; i < int'(len); i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum ^ b;
         send_byte(b);
      end
      send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   // Hold the sender off until every owed word has been popped.
   task automatic wait_drained();
      while (decoder.pending() != 0)
         @(negedge clock);
   endtask

   // Result side: pop words with random stalls and check each one.
   initial begin : result_drain
      int      stall;
      bit      steady;
      rsp_type got;
      steady  = 1'b0;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 39) == 0)
            steady = !steady;
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got.kind = rsp_kind;
         got.cmd  = rsp_command_code;
         got.data = rsp_data_byte;
         got.len  = rsp_frame_length;
         got.last = rsp_last;
         decoder.check_word(got);
         @(negedge clock);
      end
   end

   // Sender side: directed cases, a full drain, then random traffic.
   initial begin : byte_feed
      int         pick;
      int         random_end;
      logic [7:0] len;
      decoder     = new();
      reset       = 1'b1;
      req_push    = 1'b0;
      req_rx_byte = 8'h00;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Idle bytes at both extremes.
      send_byte(8'h00);
      send_byte(8'hFF);
      // Empty frame with the top command code, then a one-byte frame.
      send_frame(8'd0, 8'hFF, 1'b1);
      send_frame(8'd1, 8'h00, 1'b1);
      // Header mismatch where the 'M' and where the '<' belong.
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_byte(CHAR_M);
      // Length just above capacity.
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_M);
      send_byte(CHAR_LT);
      send_byte(8'(FRAME_CAPACITY + 1));
      // Bad checksum drops the frame.
      send_frame(8'd0, 8'h12, 1'b0);

      req_push <= 1'b0;
      wait_drained();

      // Random traffic, mostly well-formed frames with a full-size one up front.
      random_end = fed_bytes + RANDOM_BYTES;
      send_frame(8'(FRAME_CAPACITY), 8'($urandom_range(0, 255)), 1'b1);
      while (fed_bytes < random_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            if (pick == 0)
               len = 8'(FRAME_CAPACITY);
            else if ($urandom_range(0, 3) == 0)
               len = 8'($urandom_range(0, 16));
            else
               len = 8'($urandom_range(0, 6));
            send_frame(len, 8'($urandom_range(0, 255)), 1'b1);
         end else if (pick < 72) begin
            send_frame(8'($urandom_range(0, 6)), 8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 79) begin
            send_byte(CHAR_DOLLAR);
            send_byte(CHAR_M);
            send_byte(CHAR_LT);
            send_byte(8'($urandom_range(FRAME_CAPACITY + 1, 255)));
         end else if (pick < 88) begin
            // Broken header or a frame cut short; later bytes land wherever the parser is.
            send_byte(CHAR_DOLLAR);
            case ($urandom_range(0, 2))
               0: send_byte(8'($urandom_range(0, 255)));
               1: begin
                  send_byte(CHAR_M);
                  send_byte(8'($urandom_range(0, 255)));
               end
               default: begin
                  send_byte(CHAR_M);
                  send_byte(CHAR_LT);
                  send_byte(8'($urandom_range(2, 8)));
                  send_byte(8'($urandom_range(0, 255)));
                  send_byte(8'($urandom_range(0, 255)));
               end
            endcase
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end

      req_push <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (decoder.bad_words == 0 && decoder.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
